// File: rtl/cb32_pkg.sv
// Package for the CRC-32 / base32 text encoder.
// Holds item types, CRC constants and the byte-wise CRC and alphabet functions.
// No dependencies.
`default_nettype none

package cb32_pkg;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam int GROUP_W    = 5;
    localparam int BYTE_W     = 8;
    localparam int CRC_W      = 32;
    localparam int BUF_W      = BYTE_W + CRC_W + GROUP_W;
    localparam int CNT_W      = $clog2(BUF_W + 1);
    localparam int ALPHA_LETTERS = 26;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [6:0] symbol_char;
        logic       end_of_text;
    } out_item_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic [6:0] b32_char(input logic [4:0] g);
        logic [6:0] ch;
        if (g < 5'(ALPHA_LETTERS)) begin
            ch = 7'h41 + {2'd0, g};
        end
        else begin
            ch = 7'h18 + {2'd0, g};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cb32_crc.sv
// Running CRC-32 register for the encoder.
// Depends on cb32_pkg for the CRC constants and byte update function.
`default_nettype none

module cb32_crc (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic      [31:0] crc_final
);
    import cb32_pkg::*;

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_upd;

    always_comb
    begin
        crc_upd   = crc_byte(crc_reg, data_byte);
        crc_final = crc_upd ^ CRC_INIT;
        crc_next  = crc_reg;
        if (load) begin
            crc_next = last_byte ? CRC_INIT : crc_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg <= CRC_INIT;
        end
        else begin
            crc_reg <= crc_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cb32_packer.sv
// Base32 bit buffer: packs bytes and the final CRC, drains one character per cycle while char_stall is low.
// Depends on cb32_pkg for item types, buffer sizes and the alphabet function.
`default_nettype none

module cb32_packer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load_valid,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  last_byte,
    input  wire logic [31:0]           crc_final,
    output logic                       load,
    output logic                       char_valid,
    input  wire logic                  char_stall,
    output cb32_pkg::out_item_t        char_data
);
    import cb32_pkg::*;

    logic [BUF_W-1:0] bits_reg, bits_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             flush_reg, flush_next;

    logic             emit;
    logic [CNT_W-1:0] rem;
    logic [BUF_W-1:0] shifted;
    logic [BUF_W-1:0] payload;
    logic [31:0]      crc_stream;

    always_comb
    begin
        char_valid = (cnt_reg >= CNT_W'(GROUP_W)) || (flush_reg && cnt_reg != '0);
        char_data.symbol_char = b32_char(bits_reg[BUF_W-1 -: GROUP_W]);
        char_data.end_of_text = flush_reg && (cnt_reg <= CNT_W'(GROUP_W));
        emit = char_valid && !char_stall;

        if (emit) begin
            rem     = (cnt_reg > CNT_W'(GROUP_W)) ? cnt_reg - CNT_W'(GROUP_W) : '0;
            shifted = bits_reg << GROUP_W;
        end
        else begin
            rem     = cnt_reg;
            shifted = bits_reg;
        end

        load = load_valid && (rem < CNT_W'(GROUP_W)) && (!flush_reg || rem == '0);

        crc_stream = last_byte ? {crc_final[7:0], crc_final[15:8],
                                  crc_final[23:16], crc_final[31:24]} : 32'd0;
        payload    = {data_byte, crc_stream, {GROUP_W{1'b0}}} >> rem;

        if (load) begin
            bits_next  = shifted | payload;
            cnt_next   = rem + (last_byte ? CNT_W'(BYTE_W + CRC_W) : CNT_W'(BYTE_W));
            flush_next = last_byte;
        end
        else begin
            bits_next  = shifted;
            cnt_next   = rem;
            flush_next = flush_reg && (rem != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bits_reg  <= '0;
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
        end
        else begin
            bits_reg  <= bits_next;
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/crc32_base32_encoder_top.sv
// Top level of the CRC-32 / base32 text encoder.
// A byte is held in item_reg on acceptance and enters the bit buffer once that has room;
// its first character comes from the registered bit buffer. Characters leave one per
// cycle while char_stall is low: one or two per byte, eight or nine for a last byte.
// Reset: CRC returns to all ones and the buffer empties; a text ends with end_of_text.
// Depends on cb32_pkg, cb32_crc and cb32_packer.
`default_nettype none

module crc32_base32_encoder_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire cb32_pkg::in_item_t  byte_data,
    output logic                     char_valid,
    input  wire logic                char_stall,
    output cb32_pkg::out_item_t      char_data
);
    import cb32_pkg::*;

    in_item_t    item_reg;
    logic        valid_reg, valid_next;
    logic        load;
    logic        accept;
    logic [31:0] crc_final;

    always_comb
    begin
        byte_stall = valid_reg && !load;
        accept     = byte_valid && !byte_stall;
        valid_next = accept || (valid_reg && !load);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            item_reg <= byte_data;
        end
    end

    cb32_crc u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .data_byte (item_reg.data_byte),
        .last_byte (item_reg.last_byte),
        .crc_final (crc_final)
    );

    cb32_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (valid_reg),
        .data_byte  (item_reg.data_byte),
        .last_byte  (item_reg.last_byte),
        .crc_final  (crc_final),
        .load       (load),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

endmodule

`default_nettype wire
